// ----- design/gsocd_pkg.sv -----
package gsocd_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int MAX_COLS    = 1024;
  localparam int ROW_W       = 16;
  localparam int GRID_COLS_W = 11;
  localparam int COL_W       = $clog2(MAX_COLS + 1);
  localparam int RCOL_W      = $clog2(MAX_COLS);
  localparam int SEEN_W      = $clog2(3 * MAX_COLS + 1);

  localparam int HIST_AW     = $clog2(6 * MAX_COLS + 1);
  localparam int HIST_DEPTH  = 1 << HIST_AW;
  localparam int ROW_TAPS    = 5;
  localparam int WIN_TAPS    = 7;
  localparam int WIN_HALF    = (WIN_TAPS - 1) / 2;
  localparam int BANK_SEL_W  = $clog2(WIN_TAPS);
  localparam int BANKS       = 1 << BANK_SEL_W;
  localparam int BANK_AW     = HIST_AW - BANK_SEL_W;
  localparam int BANK_DEPTH  = 1 << BANK_AW;

  localparam int BORDER      = 9;
  localparam int COEF_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int PROD_W      = COEF_W + DIFF_W;
  localparam int SUM_W       = PROD_W + 2;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COEF_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COEF_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COEF_3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COEF_1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COEF_2 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COEF_3 = 3'd7;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  localparam logic [ROW_W-1:0]       GRID_ROWS_RESET = ROW_W'(64);
  localparam logic [GRID_COLS_W-1:0] GRID_COLS_RESET = GRID_COLS_W'(64);
  localparam logic [COEF_W-1:0]      COEF_1_RESET    = COEF_W'(49152);
  localparam logic [COEF_W-1:0]      COEF_2_RESET    = COEF_W'(-9830);
  localparam logic [COEF_W-1:0]      COEF_3_RESET    = COEF_W'(1092);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [HIST_AW-1:0] haddr_t;

  typedef struct packed {
    logic                             we;
    haddr_t                           waddr;
    sample_t                          wdata;
    logic                             re;
    logic [ROW_TAPS-1:0][HIST_AW-1:0] row_addr;
    logic [ROW_TAPS-1:0]              row_ok;
    haddr_t                           win_addr;
    logic [WIN_TAPS-1:0]              win_ok;
  } hist_req_t;

  typedef logic [ROW_TAPS-1:0][SAMPLE_W-1:0] row_taps_t;
  typedef logic [WIN_TAPS-1:0][SAMPLE_W-1:0] win_taps_t;

  typedef struct packed {
    logic    emit;
    logic    row_en;
    logic    col_en;
    logic    last;
    sample_t sample;
  } item_t;

  typedef struct packed {
    logic [2:0][COEF_W-1:0] row;
    logic [2:0][COEF_W-1:0] col;
  } coefs_t;

endpackage

// ----- design/gsocd_ram.sv -----
module gsocd_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

// ----- design/gsocd_hist.sv -----
module gsocd_hist import gsocd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  hist_req_t req,
  output row_taps_t row_tap,
  output win_taps_t win_tap
);

  logic [SAMPLE_W-1:0]   row_q [ROW_TAPS];
  logic [SAMPLE_W-1:0]   bank_q [BANKS];
  logic [ROW_TAPS-1:0]   row_ok_r;
  logic [WIN_TAPS-1:0]   win_ok_r;
  logic [BANK_SEL_W-1:0] rot_r;

  for (genvar j = 0; j < ROW_TAPS; j++) begin : g_row
    gsocd_ram #(.DEPTH(HIST_DEPTH), .WIDTH(SAMPLE_W)) u_ram (
      .clk     (clk),
      .we      (req.we),
      .waddr   (req.waddr),
      .wdata   (req.wdata),
      .re      (req.re),
      .raddr   (req.row_addr[j]),
      .rdata_r (row_q[j])
    );
  end

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [BANK_SEL_W-1:0] ofs;
    haddr_t                addr;
    logic                  bank_we;

    assign ofs     = BANK_SEL_W'(b) - req.win_addr[BANK_SEL_W-1:0];
    assign addr    = req.win_addr + HIST_AW'(ofs);
    assign bank_we = req.we && (req.waddr[BANK_SEL_W-1:0] == BANK_SEL_W'(b));

    gsocd_ram #(.DEPTH(BANK_DEPTH), .WIDTH(SAMPLE_W)) u_ram (
      .clk     (clk),
      .we      (bank_we),
      .waddr   (req.waddr[HIST_AW-1:BANK_SEL_W]),
      .wdata   (req.wdata),
      .re      (req.re),
      .raddr   (addr[HIST_AW-1:BANK_SEL_W]),
      .rdata_r (bank_q[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r <= '0;
      win_ok_r <= '0;
      rot_r    <= '0;
    end else if (req.re) begin
      row_ok_r <= req.row_ok;
      win_ok_r <= req.win_ok;
      rot_r    <= req.win_addr[BANK_SEL_W-1:0];
    end
  end

  // taps older than the fill count read as zero
  always_comb begin
    logic [BANK_SEL_W-1:0] sel;
    sel = '0;
    for (int j = 0; j < ROW_TAPS; j++) begin
      row_tap[j] = row_ok_r[j] ? row_q[j] : '0;
    end
    for (int o = 0; o < WIN_TAPS; o++) begin
      sel        = rot_r + BANK_SEL_W'(o);
      win_tap[o] = win_ok_r[o] ? bank_q[sel] : '0;
    end
  end

endmodule

// ----- design/gsocd_ctrl.sv -----
module gsocd_ctrl import gsocd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_fire,
  input  logic                  in_operation,
  input  sample_t               in_sample,
  output hist_req_t             hreq,
  output item_t                 item,
  output coefs_t                coefs
);

  localparam int RW1 = ROW_W + 1;
  localparam int CW  = COL_W + 4;

  typedef struct packed {
    logic [COL_W-1:0]                 cols;
    logic [SEEN_W-1:0]                seen_lim;
    logic [ROW_TAPS-1:0][HIST_AW-1:0] row_age;
    haddr_t                           win_base;
  } geom_t;

  function automatic geom_t geom_f(input logic [GRID_COLS_W-1:0] raw);
    geom_t  g;
    haddr_t c1;
    haddr_t c2;
    haddr_t c3;
    haddr_t c4;
    if (raw == '0) begin
      g.cols = COL_W'(1);
    end else if (int'(raw) > MAX_COLS) begin
      g.cols = COL_W'(MAX_COLS);
    end else begin
      g.cols = COL_W'(raw);
    end
    c1 = HIST_AW'(g.cols);
    c2 = c1 << 1;
    c4 = c1 << 2;
    c3 = c2 + c1;
    g.seen_lim   = SEEN_W'(c3);
    g.row_age[0] = c1;
    g.row_age[1] = c2;
    g.row_age[2] = c4;
    g.row_age[3] = c4 + c1;
    g.row_age[4] = c4 + c2;
    g.win_base   = c3 + HIST_AW'(WIN_HALF);
    return g;
  endfunction

  logic [ROW_W-1:0]  rows_e_r;
  geom_t             geom_r;
  coefs_t            coefs_r;
  haddr_t            wp_r;
  haddr_t            fill_r;
  logic [SEEN_W-1:0] seen_r,    seen_nxt;
  logic [ROW_W-1:0]  res_row_r, res_row_nxt;
  logic [RCOL_W-1:0] res_col_r, res_col_nxt;

  logic    emit;
  logic    row_en;
  logic    col_en;
  logic    row_last;
  logic    col_last;
  logic    last;
  sample_t v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_e_r        <= GRID_ROWS_RESET;
      geom_r          <= geom_f(GRID_COLS_RESET);
      coefs_r.row[0]  <= COEF_1_RESET;
      coefs_r.row[1]  <= COEF_2_RESET;
      coefs_r.row[2]  <= COEF_3_RESET;
      coefs_r.col[0]  <= COEF_1_RESET;
      coefs_r.col[1]  <= COEF_2_RESET;
      coefs_r.col[2]  <= COEF_3_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_ROWS: begin
          rows_e_r <= (cfg_data[ROW_W-1:0] == '0) ? ROW_W'(1) : cfg_data[ROW_W-1:0];
        end
        REG_GRID_COLS:  geom_r         <= geom_f(cfg_data[GRID_COLS_W-1:0]);
        REG_ROW_COEF_1: coefs_r.row[0] <= cfg_data[COEF_W-1:0];
        REG_ROW_COEF_2: coefs_r.row[1] <= cfg_data[COEF_W-1:0];
        REG_ROW_COEF_3: coefs_r.row[2] <= cfg_data[COEF_W-1:0];
        REG_COL_COEF_1: coefs_r.col[0] <= cfg_data[COEF_W-1:0];
        REG_COL_COEF_2: coefs_r.col[1] <= cfg_data[COEF_W-1:0];
        REG_COL_COEF_3: coefs_r.col[2] <= cfg_data[COEF_W-1:0];
      endcase
    end
  end

  assign v        = (in_operation == OP_FLUSH) ? '0 : in_sample;
  assign emit     = seen_r >= geom_r.seen_lim;
  assign row_en   = (res_row_r >= ROW_W'(BORDER)) &&
                    (RW1'(res_row_r) + RW1'(BORDER) < RW1'(rows_e_r));
  assign col_en   = (CW'(res_col_r) >= CW'(BORDER)) &&
                    (CW'(res_col_r) + CW'(BORDER) < CW'(geom_r.cols));
  assign row_last = RW1'(res_row_r) + RW1'(1) >= RW1'(rows_e_r);
  assign col_last = CW'(res_col_r) + CW'(1) >= CW'(geom_r.cols);
  assign last     = row_last && col_last;

  always_comb begin
    seen_nxt    = seen_r;
    res_row_nxt = res_row_r;
    res_col_nxt = res_col_r;
    priority if (!emit) begin
      seen_nxt = seen_r + SEEN_W'(1);
    end else if (last) begin
      seen_nxt    = '0;
      res_row_nxt = '0;
      res_col_nxt = '0;
    end else if (col_last) begin
      res_col_nxt = '0;
      res_row_nxt = res_row_r + ROW_W'(1);
    end else begin
      res_col_nxt = res_col_r + RCOL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      fill_r    <= '0;
      seen_r    <= '0;
      res_row_r <= '0;
      res_col_r <= '0;
    end else if (in_fire) begin
      wp_r      <= wp_r + HIST_AW'(1);
      fill_r    <= (fill_r == '1) ? fill_r : fill_r + HIST_AW'(1);
      seen_r    <= seen_nxt;
      res_row_r <= res_row_nxt;
      res_col_r <= res_col_nxt;
    end
  end

  always_comb begin
    haddr_t age;
    age        = '0;
    hreq.we    = in_fire;
    hreq.waddr = wp_r;
    hreq.wdata = v;
    hreq.re    = in_fire && emit;
    for (int j = 0; j < ROW_TAPS; j++) begin
      hreq.row_addr[j] = wp_r - geom_r.row_age[j];
      hreq.row_ok[j]   = geom_r.row_age[j] <= fill_r;
    end
    hreq.win_addr = wp_r - geom_r.win_base;
    for (int o = 0; o < WIN_TAPS; o++) begin
      age            = geom_r.win_base - HIST_AW'(o);
      hreq.win_ok[o] = age <= fill_r;
    end
  end

  assign item.emit   = emit;
  assign item.row_en = row_en;
  assign item.col_en = col_en;
  assign item.last   = last;
  assign item.sample = v;
  assign coefs       = coefs_r;

endmodule

// ----- design/gsocd_arith.sv -----
module gsocd_arith import gsocd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  item_t     item,
  input  row_taps_t row_tap,
  input  win_taps_t win_tap,
  input  coefs_t    coefs,
  output logic      ready,
  input  logic      out_stall,
  output logic      out_valid,
  output sample_t   out_row_derivative,
  output sample_t   out_col_derivative,
  output logic      out_last_point
);

  typedef struct packed {
    logic row_en;
    logic col_en;
    logic last;
  } flags_t;

  function automatic logic signed [DIFF_W-1:0] sdiff(input logic [SAMPLE_W-1:0] a,
                                                     input logic [SAMPLE_W-1:0] b);
    return $signed({a[SAMPLE_W-1], a}) - $signed({b[SAMPLE_W-1], b});
  endfunction

  function automatic sample_t sat_shift(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-FRAC_W-1:0]        q;
    logic [SUM_W-FRAC_W-SAMPLE_W:0] top;
    q   = s[SUM_W-1:FRAC_W];
    top = q[SUM_W-FRAC_W-1:SAMPLE_W-1];
    if ((&top) || !(|top)) begin
      return q[SAMPLE_W-1:0];
    end else if (q[SUM_W-FRAC_W-1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

  logic rdy_o, rdy2, rdy3, rdy4;

  logic    s1_v_r;
  item_t   s1_r;
  logic    s2_v_r;
  flags_t  s2_fl_r;
  logic signed [DIFF_W-1:0] s2_rd_r [3];
  logic signed [DIFF_W-1:0] s2_cd_r [3];
  logic    s3_v_r;
  flags_t  s3_fl_r;
  logic signed [PROD_W-1:0] s3_rp_r [3];
  logic signed [PROD_W-1:0] s3_cp_r [3];
  logic    s4_v_r;
  flags_t  s4_fl_r;
  logic signed [SUM_W-1:0]  s4_rs_r;
  logic signed [SUM_W-1:0]  s4_cs_r;
  logic    out_valid_r;
  sample_t out_row_r;
  sample_t out_col_r;
  logic    out_last_r;

  logic signed [DIFF_W-1:0] rd [3];
  logic signed [DIFF_W-1:0] cd [3];

  assign rdy_o = !out_valid_r || !out_stall;
  assign rdy4  = !s4_v_r || rdy_o;
  assign rdy3  = !s3_v_r || rdy4;
  assign rdy2  = !s2_v_r || rdy3;
  assign ready = !s1_v_r || rdy2;

  always_comb begin
    rd[0] = sdiff(row_tap[1], row_tap[2]);
    rd[1] = sdiff(row_tap[0], row_tap[3]);
    rd[2] = sdiff(s1_r.sample, row_tap[4]);
    cd[0] = sdiff(win_tap[4], win_tap[2]);
    cd[1] = sdiff(win_tap[5], win_tap[1]);
    cd[2] = sdiff(win_tap[6], win_tap[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ready) begin
        s1_v_r <= load;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
      if (rdy4) begin
        s4_v_r <= s3_v_r;
      end
      if (rdy_o) begin
        out_valid_r <= s4_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      s1_r <= item;
    end
    if (rdy2 && s1_v_r) begin
      s2_fl_r <= '{row_en: s1_r.row_en, col_en: s1_r.col_en, last: s1_r.last};
      for (int k = 0; k < 3; k++) begin
        s2_rd_r[k] <= rd[k];
        s2_cd_r[k] <= cd[k];
      end
    end
    if (rdy3 && s2_v_r) begin
      s3_fl_r <= s2_fl_r;
      for (int k = 0; k < 3; k++) begin
        s3_rp_r[k] <= PROD_W'($signed(coefs.row[k])) * PROD_W'(s2_rd_r[k]);
        s3_cp_r[k] <= PROD_W'($signed(coefs.col[k])) * PROD_W'(s2_cd_r[k]);
      end
    end
    if (rdy4 && s3_v_r) begin
      s4_fl_r <= s3_fl_r;
      s4_rs_r <= SUM_W'(s3_rp_r[0]) + SUM_W'(s3_rp_r[1]) + SUM_W'(s3_rp_r[2]);
      s4_cs_r <= SUM_W'(s3_cp_r[0]) + SUM_W'(s3_cp_r[1]) + SUM_W'(s3_cp_r[2]);
    end
    if (rdy_o && s4_v_r) begin
      out_row_r  <= s4_fl_r.row_en ? sat_shift(s4_rs_r) : '0;
      out_col_r  <= s4_fl_r.col_en ? sat_shift(s4_cs_r) : '0;
      out_last_r <= s4_fl_r.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_row_derivative = out_row_r;
  assign out_col_derivative = out_col_r;
  assign out_last_point     = out_last_r;

endmodule

// ----- design/grid_sixth_order_central_difference.sv -----
// A result passes s1, s2, s3, s4 and the output register. One beat per cycle while in_stall
// is low; each history RAM copy takes one write and one read per cycle, each window bank one
// read and at most one write, and the arithmetic pipeline advances one item per cycle unless
// out_stall holds it. The first 3*grid_cols beats of a grid give no result; flush beats drain
// the last rows. Reset (rst_n low, synchronous) clears counters, pipeline valids and registers;
// history contents are kept, and taps older than the fill count read as zero, so no clearing pass.
module grid_sixth_order_central_difference import gsocd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  sample_t               in_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sample_t               out_row_derivative,
  output sample_t               out_col_derivative,
  output logic                  out_last_point,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic      ready;
  logic      in_fire;
  hist_req_t hreq;
  item_t     item;
  coefs_t    coefs;
  row_taps_t row_tap;
  win_taps_t win_tap;

  assign in_stall  = !ready;
  assign in_fire   = in_valid && ready;
  assign cfg_ready = 1'b1;

  gsocd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_fire      (in_fire),
    .in_operation (in_operation),
    .in_sample    (in_sample),
    .hreq         (hreq),
    .item         (item),
    .coefs        (coefs)
  );

  gsocd_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (hreq),
    .row_tap (row_tap),
    .win_tap (win_tap)
  );

  gsocd_arith u_arith (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (in_fire && item.emit),
    .item               (item),
    .row_tap            (row_tap),
    .win_tap            (win_tap),
    .coefs              (coefs),
    .ready              (ready),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_row_derivative (out_row_derivative),
    .out_col_derivative (out_col_derivative),
    .out_last_point     (out_last_point)
  );

endmodule

// ----- design/gsocd_check.sv -----
module gsocd_check import gsocd_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_stall,
  input logic    out_valid,
  input logic    out_stall,
  input sample_t out_row_derivative,
  input sample_t out_col_derivative,
  input logic    out_last_point
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row_derivative) &&
      $stable(out_col_derivative) && $stable(out_last_point))
    else $error("stalled result beat changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output side free");

  a_last_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_point |-> out_row_derivative == '0 && out_col_derivative == '0)
    else $error("final point result outside border zone");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not cleared by reset");

endmodule

bind grid_sixth_order_central_difference gsocd_check u_check (.*);
